>>> rtl/squish_trajectory_simplifier_top_assert.svh
// Assertion macros shared by the trajectory simplifier RTL.
// Included by the top level, which checks its own control logic; no other dependencies.
`ifndef SQUISH_TRAJECTORY_SIMPLIFIER_TOP_ASSERT_SVH
`define SQUISH_TRAJECTORY_SIMPLIFIER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define STS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define STS_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define STS_ASSERT(lbl, clk, rstn, prop)
`define STS_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

>>> rtl/sts_pkg.sv
// Shared types, constants and helper functions of the trajectory simplifier.
// No dependencies; imported by every module of the block.
`default_nettype none
package sts_pkg;

    localparam int PRIO_W  = 31;
    localparam int DIST_W  = 30;
    localparam int LIMIT_W = 7;

    localparam logic [PRIO_W-1:0]  SENTINEL    = 31'h4000_0000;
    localparam logic [PRIO_W-1:0]  PRIO_MAX    = 31'h3FFF_FFFF;
    localparam logic [PRIO_W-1:0]  PRIO_TOP    = 31'h7FFF_FFFF;
    localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 7'd5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd32;

    // One retained trajectory point.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        t;
        logic [31:0]        idx;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

    // Request to the distance unit: predecessor, current and next point.
    typedef struct packed {
        logic   start;
        entry_t p;
        entry_t c;
        entry_t q;
    } sed_req_t;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] sed_dist;
    } sed_rsp_t;

    // Priority sum that saturates just below the sentinel.
    function automatic logic [PRIO_W-1:0] sat_add(input logic [PRIO_W-1:0] a,
                                                  input logic [PRIO_W-1:0] b);
        logic [PRIO_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, PRIO_MAX}) ? PRIO_MAX : s[PRIO_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/squish_trajectory_simplifier_top.sv
// Trajectory simplifier top level; uses sts_pkg, sts_store, sts_sed and the assertion header.
// Throughput: one point per cycle while fewer than two points are held; otherwise no new
// point is taken while sts_sed runs its serial divider and root (the root is skipped when
// the distance saturates early), nor during the minimum scan and shift when a point drops.
// A final point starts a flush: each kept point is read, then loaded to the output register
// while the output is free; reset empties the run, limit 32.
`default_nettype none
`include "squish_trajectory_simplifier_top_assert.svh"
module squish_trajectory_simplifier_top
    import sts_pkg::*;
#(
    parameter int MAX_BUFFER = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic [6:0]    cfg_wdata,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [95:0]   s_tdata,   // pos_x, pos_y, stamp
    input  wire logic          s_tlast,   // final_point
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [127:0]       m_tdata,   // point_index, kept_x, kept_y, kept_stamp
    output logic               m_tlast    // end_of_run
);

    localparam int DEPTH = MAX_BUFFER + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_BUFFER + 2);
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = LIMIT_W'(MAX_BUFFER);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_RD_P    = 10'b00_0000_0010,
        ST_CAP_C   = 10'b00_0000_0100,
        ST_SED_RUN = 10'b00_0000_1000,
        ST_WR_C    = 10'b00_0001_0000,
        ST_SCAN    = 10'b00_0010_0000,
        ST_WR_M1   = 10'b00_0100_0000,
        ST_SHIFT   = 10'b00_1000_0000,
        ST_FL_RD   = 10'b01_0000_0000,
        ST_FL_LD   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] held_reg, held_next;
    logic [31:0] arrival_reg, arrival_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic final_reg, final_next;
    entry_t new_reg, new_next, p_reg, p_next, c_reg, c_next;
    logic [CW-1:0] idx_reg, idx_next, cmp_reg, cmp_next, min_idx_reg, min_idx_next;
    logic [CW-1:0] wr_ptr_reg, wr_ptr_next;
    logic pend_reg, pend_next, first_reg, first_next;
    logic [PRIO_W-1:0] min_prio_reg, min_prio_next;
    logic m_valid_reg, m_valid_next, m_last_reg, m_last_next;
    logic [127:0] m_data_reg, m_data_next;

    logic mem_we, mem_re;
    logic [CW-1:0] mem_waddr_w, mem_raddr_w;
    entry_t mem_wdata, mem_rdata;
    sed_req_t sed_req;
    sed_rsp_t sed_rsp;

    logic accept, out_free, drop;
    logic [LIMIT_W-1:0] lim;
    logic [CW-1:0] held_m1, held_m2, min_m1;
    entry_t in_entry;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign held_m1  = held_reg - CW'(1);
    assign held_m2  = held_reg - CW'(2);
    assign min_m1   = min_idx_reg - CW'(1);

    // Effective limit, saturated to the supported range.
    always_comb begin
        if (limit_reg < LIMIT_MIN) begin
            lim = LIMIT_MIN;
        end else if (limit_reg > LIMIT_MAX) begin
            lim = LIMIT_MAX;
        end else begin
            lim = limit_reg;
        end
    end

    // The count of prioritised entries equals the index of the newest point.
    assign drop = (8'(held_m1) >= 8'(lim));

    always_comb begin
        in_entry.x    = s_tdata[31:0];
        in_entry.y    = s_tdata[63:32];
        in_entry.t    = s_tdata[95:64];
        in_entry.idx  = arrival_reg;
        in_entry.prio = (held_reg == '0) ? SENTINEL : '0;
    end

    sts_store #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_store (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr_w[AW-1:0]),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr_w[AW-1:0]),
        .rdata(mem_rdata)
    );

    assign sed_req.start = (state_reg == ST_CAP_C);
    assign sed_req.p     = p_reg;
    assign sed_req.c     = mem_rdata;
    assign sed_req.q     = new_reg;

    sts_sed u_sed (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (sed_req),
        .rsp    (sed_rsp)
    );

    // Control sequencer: append, update priority, drop the lowest, flush.
    always_comb begin
        state_next    = state_reg;
        held_next     = held_reg;
        arrival_next  = arrival_reg;
        limit_next    = cfg_we ? cfg_wdata : limit_reg;
        final_next    = final_reg;
        new_next      = new_reg;
        p_next        = p_reg;
        c_next        = c_reg;
        idx_next      = idx_reg;
        cmp_next      = cmp_reg;
        min_idx_next  = min_idx_reg;
        min_prio_next = min_prio_reg;
        wr_ptr_next   = wr_ptr_reg;
        pend_next     = 1'b0;
        first_next    = first_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_last_next   = m_last_reg;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_waddr_w   = held_reg;
        mem_wdata     = in_entry;
        mem_re        = 1'b0;
        mem_raddr_w   = held_m2;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    mem_we       = 1'b1;
                    mem_re       = 1'b1;
                    new_next     = in_entry;
                    held_next    = held_reg + CW'(1);
                    arrival_next = arrival_reg + 32'd1;
                    final_next   = s_tlast;
                    idx_next     = '0;
                    if (held_reg >= CW'(2)) begin
                        state_next = ST_RD_P;
                    end else if (s_tlast) begin
                        state_next = ST_FL_RD;
                    end
                end
            end
            ST_RD_P: begin
                p_next     = mem_rdata;
                mem_re     = 1'b1;
                state_next = ST_CAP_C;
            end
            ST_CAP_C: begin
                c_next     = mem_rdata;
                state_next = ST_SED_RUN;
            end
            ST_SED_RUN: begin
                if (sed_rsp.done) begin
                    state_next = ST_WR_C;
                end
            end
            ST_WR_C: begin
                mem_we         = 1'b1;
                mem_waddr_w    = held_m2;
                mem_wdata      = c_reg;
                mem_wdata.prio = sat_add(c_reg.prio, {1'b0, sed_rsp.sed_dist});
                if (drop) begin
                    idx_next      = CW'(1);
                    min_prio_next = PRIO_TOP;
                    state_next    = ST_SCAN;
                end else if (final_reg) begin
                    idx_next   = '0;
                    state_next = ST_FL_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // Reads stream in one per cycle; each compare follows its read in the next cycle.
                if (idx_reg <= held_m2) begin
                    mem_re      = 1'b1;
                    mem_raddr_w = idx_reg;
                    idx_next    = idx_reg + CW'(1);
                    pend_next   = 1'b1;
                    cmp_next    = idx_reg;
                end
                if (pend_reg && (mem_rdata.prio < min_prio_reg)) begin
                    min_prio_next = mem_rdata.prio;
                    min_idx_next  = cmp_reg;
                end
                if (!pend_reg && (idx_reg > held_m2)) begin
                    mem_re      = 1'b1;
                    mem_raddr_w = min_m1;
                    state_next  = ST_WR_M1;
                end
            end
            ST_WR_M1: begin
                // The left neighbor gains the dropped priority unless it is the head.
                if (min_m1 != '0) begin
                    mem_we         = 1'b1;
                    mem_waddr_w    = min_m1;
                    mem_wdata      = mem_rdata;
                    mem_wdata.prio = sat_add(mem_rdata.prio, min_prio_reg);
                end
                idx_next    = min_idx_reg + CW'(1);
                wr_ptr_next = min_idx_reg;
                first_next  = 1'b1;
                state_next  = ST_SHIFT;
            end
            ST_SHIFT: begin
                // Close the gap: entry j moves to j-1, the right neighbor gains too.
                if (idx_reg <= held_m1) begin
                    mem_re      = 1'b1;
                    mem_raddr_w = idx_reg;
                    idx_next    = idx_reg + CW'(1);
                    pend_next   = 1'b1;
                end
                if (pend_reg) begin
                    mem_we      = 1'b1;
                    mem_waddr_w = wr_ptr_reg;
                    mem_wdata   = mem_rdata;
                    if (first_reg) begin
                        mem_wdata.prio = sat_add(mem_rdata.prio, min_prio_reg);
                    end
                    wr_ptr_next = wr_ptr_reg + CW'(1);
                    first_next  = 1'b0;
                end
                if (!pend_reg && (idx_reg > held_m1)) begin
                    held_next = held_m1;
                    idx_next  = '0;
                    if (final_reg) begin
                        state_next = ST_FL_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FL_RD: begin
                mem_re      = 1'b1;
                mem_raddr_w = idx_reg;
                state_next  = ST_FL_LD;
            end
            ST_FL_LD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {mem_rdata.t, mem_rdata.y, mem_rdata.x, mem_rdata.idx};
                    m_last_next  = (idx_reg == held_m1);
                    if (idx_reg == held_m1) begin
                        held_next    = '0;
                        arrival_next = 32'd0;
                        state_next   = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = ST_FL_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            held_reg    <= '0;
            arrival_reg <= 32'd0;
            limit_reg   <= LIMIT_RESET;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            arrival_reg <= arrival_next;
            limit_reg   <= limit_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        final_reg    <= final_next;
        new_reg      <= new_next;
        p_reg        <= p_next;
        c_reg        <= c_next;
        idx_reg      <= idx_next;
        cmp_reg      <= cmp_next;
        min_idx_reg  <= min_idx_next;
        min_prio_reg <= min_prio_next;
        wr_ptr_reg   <= wr_ptr_next;
        first_reg    <= first_next;
        m_last_reg   <= m_last_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // The store never holds more than one point beyond the largest limit.
    `STS_ASSERT(a_held_bound, aclk, aresetn, held_reg <= CW'(MAX_BUFFER + 1))
    // Distance results arrive only while the sequencer waits for them.
    `STS_ASSERT(a_done_in_run, aclk, aresetn, sed_rsp.done |-> state_reg == ST_SED_RUN)
    // Writes stay inside the occupied part of the store plus the new slot.
    `STS_ASSERT(a_wr_in_range, aclk, aresetn, mem_we |-> mem_waddr_w <= held_reg)
    // A flush never starts on an empty store.
    `STS_ASSERT(a_flush_nonempty, aclk, aresetn, (state_reg == ST_FL_LD) |-> held_reg != '0)
    // Loading a flushed point always presents a result item.
    `STS_ASSERT_NEXT(a_load_valid, aclk, aresetn, (state_reg == ST_FL_LD) && out_free, m_tvalid)

endmodule
`default_nettype wire

>>> rtl/sts_store.sv
// Point store of the trajectory simplifier: one write and one registered read port.
// Depends on sts_pkg for the entry type.
`default_nettype none
module sts_store
    import sts_pkg::*;
#(
    parameter int DEPTH = 33,
    parameter int AW    = 6
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire entry_t        wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output entry_t             rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // Synchronous write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/sts_sed.sv
// Synchronized Euclidean distance unit: serial divider, shared multiplier, serial root.
// Depends on sts_pkg for the request and response types.
`default_nettype none
module sts_sed
    import sts_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire sed_req_t req,
    output sed_rsp_t      rsp
);

    typedef enum logic [11:0] {
        SD_IDLE = 12'b0000_0000_0001,
        SD_DIV  = 12'b0000_0000_0010,
        SD_MX   = 12'b0000_0000_0100,
        SD_MXF  = 12'b0000_0000_1000,
        SD_MY   = 12'b0000_0001_0000,
        SD_MYF  = 12'b0000_0010_0000,
        SD_SQX  = 12'b0000_0100_0000,
        SD_SQXF = 12'b0000_1000_0000,
        SD_SQY  = 12'b0001_0000_0000,
        SD_SQYF = 12'b0010_0000_0000,
        SD_ROOT = 12'b0100_0000_0000,
        SD_FIN  = 12'b1000_0000_0000
    } sd_state_t;

    sd_state_t state_reg, state_next;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [32:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        kzero_reg, kzero_next;
    logic [31:0] magx_reg, magx_next, magy_reg, magy_next;
    logic        negx_reg, negx_next, negy_reg, negy_next;
    logic signed [31:0] px_reg, px_next, py_reg, py_next, cx_reg, cx_next, cy_reg, cy_next;
    logic signed [34:0] ex_reg, ex_next, ey_reg, ey_next;
    logic [63:0] prod_reg;
    logic [60:0] sum_reg, sum_next;
    logic [61:0] s_reg, s_next, r_reg, r_next, bit_reg, bit_next;
    logic        done_reg, done_next;
    logic [DIST_W-1:0] dist_reg, dist_next;

    logic [31:0] mul_a, mul_b;
    logic signed [32:0] den_s, num_s, dx, dy;
    logic [31:0] numc;
    logic        den_pos;
    logic [32:0] kval;
    logic [63:0] rnd;
    logic [31:0] off;
    logic signed [34:0] pint, coord_c, err;
    logic        big_x, big_y;
    logic [33:0] rem_sub;
    logic        ge;
    logic [61:0] trial;
    logic [31:0] root_rnd;

    assign kval = kzero_reg ? 33'd0 : quo_reg;
    assign rnd  = prod_reg + 64'h0000_0000_8000_0000;

    // Operand selection of the shared multiplier.
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (state_reg)
            SD_MX: begin
                mul_a = kval[31:0];
                mul_b = magx_reg;
            end
            SD_MY: begin
                mul_a = kval[31:0];
                mul_b = magy_reg;
            end
            SD_SQX: begin
                mul_a = {2'b00, ex_reg[34] ? 30'(-ex_reg) : ex_reg[29:0]};
                mul_b = mul_a;
            end
            SD_SQY: begin
                mul_a = {2'b00, ey_reg[34] ? 30'(-ey_reg) : ey_reg[29:0]};
                mul_b = mul_a;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Differences of the three points taken at start.
    always_comb begin
        den_s   = $signed({1'b0, req.q.t}) - $signed({1'b0, req.p.t});
        num_s   = $signed({1'b0, req.c.t}) - $signed({1'b0, req.p.t});
        den_pos = !den_s[32] && (den_s != 33'sd0);
        if (num_s[32]) begin
            numc = 32'd0;
        end else if (num_s[31:0] > den_s[31:0]) begin
            numc = den_s[31:0];
        end else begin
            numc = num_s[31:0];
        end
        dx = $signed({req.q.x[31], req.q.x}) - $signed({req.p.x[31], req.p.x});
        dy = $signed({req.q.y[31], req.q.y}) - $signed({req.p.y[31], req.p.y});
    end

    // Rounded offset along the segment and the coordinate error.
    always_comb begin
        logic        neg;
        logic [31:0] mag;
        logic signed [31:0] base, cur;
        neg  = (state_reg == SD_MYF) ? negy_reg : negx_reg;
        mag  = (state_reg == SD_MYF) ? magy_reg : magx_reg;
        base = (state_reg == SD_MYF) ? py_reg : px_reg;
        cur  = (state_reg == SD_MYF) ? cy_reg : cx_reg;
        off  = kval[32] ? mag : rnd[63:32];
        pint = neg ? (35'(base) - $signed({3'b000, off}))
                   : (35'(base) + $signed({3'b000, off}));
        coord_c = 35'(cur);
        err  = pint - coord_c;
    end

    assign big_x    = (ex_reg >= 35'sh0_4000_0000) || (ex_reg <= -35'sh0_4000_0000);
    assign big_y    = (ey_reg >= 35'sh0_4000_0000) || (ey_reg <= -35'sh0_4000_0000);
    assign ge       = rem_reg >= {2'b00, den_reg};
    assign rem_sub  = ge ? (rem_reg - {2'b00, den_reg}) : rem_reg;
    assign trial    = r_reg + bit_reg;
    assign root_rnd = r_reg[31:0] + {31'd0, (s_reg > r_reg)};

    // Sequencer of divide, interpolate, square and root.
    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        kzero_next = kzero_reg;
        magx_next  = magx_reg;
        magy_next  = magy_reg;
        negx_next  = negx_reg;
        negy_next  = negy_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        ex_next    = ex_reg;
        ey_next    = ey_reg;
        sum_next   = sum_reg;
        s_next     = s_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        dist_next  = dist_reg;
        unique case (state_reg)
            SD_IDLE: begin
                if (req.start) begin
                    rem_next   = {2'b00, numc};
                    den_next   = den_s[31:0];
                    kzero_next = !den_pos;
                    quo_next   = 33'd0;
                    cnt_next   = 6'd32;
                    negx_next  = dx[32];
                    negy_next  = dy[32];
                    magx_next  = dx[32] ? 32'(-dx) : dx[31:0];
                    magy_next  = dy[32] ? 32'(-dy) : dy[31:0];
                    px_next    = req.p.x;
                    py_next    = req.p.y;
                    cx_next    = req.c.x;
                    cy_next    = req.c.y;
                    state_next = SD_DIV;
                end
            end
            SD_DIV: begin
                quo_next = {quo_reg[31:0], ge};
                rem_next = {rem_sub[32:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    state_next = SD_MX;
                end
            end
            SD_MX: begin
                state_next = SD_MXF;
            end
            SD_MXF: begin
                ex_next    = err;
                state_next = SD_MY;
            end
            SD_MY: begin
                state_next = SD_MYF;
            end
            SD_MYF: begin
                ey_next    = err;
                state_next = SD_SQX;
            end
            SD_SQX: begin
                if (big_x || big_y) begin
                    done_next  = 1'b1;
                    dist_next  = PRIO_MAX[DIST_W-1:0];
                    state_next = SD_IDLE;
                end else begin
                    state_next = SD_SQXF;
                end
            end
            SD_SQXF: begin
                sum_next   = prod_reg[60:0];
                state_next = SD_SQY;
            end
            SD_SQY: begin
                state_next = SD_SQYF;
            end
            SD_SQYF: begin
                s_next     = {1'b0, sum_reg} + {1'b0, prod_reg[60:0]};
                r_next     = 62'd0;
                bit_next   = 62'd1 << 60;
                state_next = SD_ROOT;
            end
            SD_ROOT: begin
                if (s_reg >= trial) begin
                    s_next = s_reg - trial;
                    r_next = (r_reg >> 1) + bit_reg;
                end else begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == 62'd1) begin
                    state_next = SD_FIN;
                end
            end
            SD_FIN: begin
                done_next  = 1'b1;
                dist_next  = (root_rnd > {1'b0, PRIO_MAX}) ? PRIO_MAX[DIST_W-1:0]
                                                           : root_rnd[DIST_W-1:0];
                state_next = SD_IDLE;
            end
            default: begin
                state_next = SD_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SD_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        kzero_reg <= kzero_next;
        magx_reg  <= magx_next;
        magy_reg  <= magy_next;
        negx_reg  <= negx_next;
        negy_reg  <= negy_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        sum_reg   <= sum_next;
        s_reg     <= s_next;
        r_reg     <= r_next;
        bit_reg   <= bit_next;
        dist_reg  <= dist_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.sed_dist = dist_reg;

endmodule
`default_nettype wire
